// File: rtl/event_counter_progress_checker_core_assert.svh
`ifndef EVENT_COUNTER_PROGRESS_CHECKER_CORE_ASSERT_SVH
`define EVENT_COUNTER_PROGRESS_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ECPC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("ecpc assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ECPC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("ecpc assertion failed");

`endif

// File: rtl/ecpc_pkg.sv
package ecpc_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int MOD_STRICT = 100;

  // func codes
  localparam logic [1:0] FUNC_FRAME  = 2'd0;
  localparam logic [1:0] FUNC_EVENT  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  // result kind
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // slave tdata layout
  localparam int S_DATA_W = 32;
  localparam int S_CH_LSB = 0;
  localparam int S_FP_BIT = 5;
  localparam int S_CRC_BIT = 6;
  localparam int S_EC_LSB = 7;
  localparam int S_CHIP_LSB = 15;

  // master tdata layout
  localparam int M_DATA_W = 24;
  localparam int M_CH_LSB = 0;
  localparam int M_CHIP_LSB = 5;
  localparam int M_AGREE_BIT = 17;
  localparam int M_CNT_LSB = 18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM
  } ctrl_state_e;

  typedef struct packed {
    logic take;        // input transaction accepted
    logic step;        // advance scan pointer
    logic emit_entry;  // load a working-channel entry
    logic emit_sum;    // load summary and clear store
  } dp_cmd_t;

  typedef struct packed {
    logic cand;       // scanned channel is present and not bad
    logic scan_end;   // scan pointer on last channel
    logic slot_free;  // output register can take a result
  } dp_sts_t;

endpackage

// File: rtl/ecpc_ctrl.sv
module ecpc_ctrl
  import ecpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic [1:0] func_i,
  output logic       s_tready_o,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FUNC_REPORT) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if ((!sts_i.cand || sts_i.slot_free) && sts_i.scan_end) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.take = accept;
      end
      ST_SCAN: begin
        cmd_o.step       = !sts_i.cand || sts_i.slot_free;
        cmd_o.emit_entry = sts_i.cand && sts_i.slot_free;
      end
      ST_SUM: begin
        cmd_o.emit_sum = sts_i.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/ecpc_dp.sv
module ecpc_dp
  import ecpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [4:0]  channel_i,
  input  logic        footprint_ok_i,
  input  logic        crc_ok_i,
  input  logic [7:0]  event_counter_i,
  input  logic [11:0] chip_ident_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic        m_tready_i,
  output logic        m_tvalid_o,
  output logic        kind_o,
  output logic [4:0]  work_channel_o,
  output logic [11:0] work_chip_o,
  output logic        counters_agree_o,
  output logic [5:0]  working_count_o,
  output logic        last_o
);

  logic strict_q;
  logic in_first_q, seen_q;
  logic [NUM_CHANNELS-1:0] known_q, bad_q, present_q;
  logic [7:0]  exp_q    [NUM_CHANNELS];
  logic [7:0]  latest_q [NUM_CHANNELS];
  logic [11:0] chip_q   [NUM_CHANNELS];

  logic [CH_W-1:0] scan_idx_q;
  logic       have_q, agree_q;
  logic [7:0] ref_q;
  logic [5:0] count_q;

  logic        m_valid_q, m_kind_q, m_agree_q, m_last_q;
  logic [4:0]  m_ch_q;
  logic [11:0] m_chip_q;
  logic [5:0]  m_cnt_q;

  // frame decode
  logic [5:0]      ch_ext;
  logic            in_range;
  logic [CH_W-1:0] ch_idx;
  logic            frame_ok, known_eff, checked, mismatch, bad_now;
  logic [8:0]      next9, next_mod;

  assign ch_ext   = {1'b0, channel_i};
  assign in_range = ch_ext < 6'(NUM_CHANNELS);
  assign ch_idx   = ch_ext[CH_W-1:0];
  assign frame_ok = cmd_i.take && func_i == FUNC_FRAME && seen_q && in_range;
  assign known_eff = known_q[ch_idx] || in_first_q;
  assign checked  = known_eff && !bad_q[ch_idx];
  assign mismatch = (event_counter_i != exp_q[ch_idx]) && !(in_first_q && !strict_q);
  assign bad_now  = !footprint_ok_i || !crc_ok_i || mismatch;
  assign next9    = {1'b0, event_counter_i} + 9'd1;

  always_comb begin
    next_mod = next9;
    if (strict_q) begin
      if (next9 >= 9'(2 * MOD_STRICT)) next_mod = next9 - 9'(2 * MOD_STRICT);
      else if (next9 >= 9'(MOD_STRICT)) next_mod = next9 - 9'(MOD_STRICT);
    end
  end

  assign sts_o.cand      = present_q[scan_idx_q] && !bad_q[scan_idx_q];
  assign sts_o.scan_end  = scan_idx_q == CH_W'(NUM_CHANNELS - 1);
  assign sts_o.slot_free = !m_valid_q || m_tready_i;

  // control and marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q   <= 1'b0;
      in_first_q <= 1'b1;
      seen_q     <= 1'b0;
      known_q    <= '0;
      bad_q      <= '0;
      present_q  <= '0;
      scan_idx_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) exp_q[i] <= '0;
    end else begin
      if (cfg_we_i) strict_q <= cfg_wdata_i;
      if (cmd_i.take && func_i == FUNC_EVENT) begin
        if (seen_q) in_first_q <= 1'b0;
        seen_q    <= 1'b1;
        present_q <= '0;
      end
      if (frame_ok) begin
        present_q[ch_idx] <= 1'b1;
        if (in_first_q) known_q[ch_idx] <= 1'b1;
        if (checked) begin
          if (bad_now) bad_q[ch_idx] <= 1'b1;
          if (!mismatch) exp_q[ch_idx] <= next_mod[7:0];
        end
      end
      if (cmd_i.step && !sts_o.scan_end) scan_idx_q <= scan_idx_q + CH_W'(1);
      if (cmd_i.emit_sum) begin
        in_first_q <= 1'b1;
        seen_q     <= 1'b0;
        known_q    <= '0;
        bad_q      <= '0;
        present_q  <= '0;
        scan_idx_q <= '0;
        for (int i = 0; i < NUM_CHANNELS; i++) exp_q[i] <= '0;
      end
    end
  end

  // latest counter and chip id, written by every frame taken after an event start
  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      latest_q[ch_idx] <= event_counter_i;
      chip_q[ch_idx]   <= chip_ident_i;
    end
  end

  // agreement tracking over the report scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      agree_q <= 1'b1;
      count_q <= '0;
    end else if (cmd_i.take && func_i == FUNC_REPORT) begin
      have_q  <= 1'b0;
      agree_q <= 1'b1;
      count_q <= '0;
    end else if (cmd_i.emit_entry) begin
      have_q  <= 1'b1;
      count_q <= count_q + 6'd1;
      if (have_q && latest_q[scan_idx_q] != ref_q) agree_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_entry && !have_q) ref_q <= latest_q[scan_idx_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit_entry || cmd_i.emit_sum) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_entry) begin
      m_kind_q  <= KIND_ENTRY;
      m_ch_q    <= 5'(scan_idx_q);
      m_chip_q  <= chip_q[scan_idx_q];
      m_agree_q <= 1'b0;
      m_cnt_q   <= '0;
      m_last_q  <= 1'b0;
    end else if (cmd_i.emit_sum) begin
      m_kind_q  <= KIND_SUMMARY;
      m_ch_q    <= '0;
      m_chip_q  <= '0;
      m_agree_q <= agree_q;
      m_cnt_q   <= count_q;
      m_last_q  <= 1'b1;
    end
  end

  assign m_tvalid_o       = m_valid_q;
  assign kind_o           = m_kind_q;
  assign work_channel_o   = m_ch_q;
  assign work_chip_o      = m_chip_q;
  assign counters_agree_o = m_agree_q;
  assign working_count_o  = m_cnt_q;
  assign last_o           = m_last_q;

endmodule

// File: rtl/event_counter_progress_checker_core.sv
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tuser=func, tdata=frame fields
// m_axis    out  tvalid/tready      tuser=kind, tlast=last, tdata=report fields
// cfg       in   cfg_we_i           cfg_wdata_i = strict_mode
//
// Frame and event-start transactions may follow back to back. A report
// transaction walks the channel store one channel per cycle while the master
// side does not stall (each entry waits for the single output register), then
// loads the summary. Input is held off for the whole report. Reset is
// asynchronous, active low, and clears all marks and expected counters; the
// summary transaction clears them again.
module event_counter_progress_checker_core
  import ecpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tuser: [1:0] func
  input  logic [1:0]          s_axis_tuser,
  // tdata: [4:0] channel, [5] footprint_ok, [6] crc_ok, [14:7] event_counter,
  //        [26:15] chip_ident, [31:27] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tuser: [0] kind
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  // tdata: [4:0] work_channel, [16:5] work_chip, [17] counters_agree,
  //        [23:18] working_count
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [4:0]  work_channel;
  logic [11:0] work_chip;
  logic        counters_agree;
  logic [5:0]  working_count;

  // Sequence the report scan; accept input only when idle.
  ecpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .func_i     (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold per-channel marks and counters, check frames, build results.
  ecpc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (s_axis_tuser),
    .channel_i        (s_axis_tdata[S_CH_LSB +: 5]),
    .footprint_ok_i   (s_axis_tdata[S_FP_BIT]),
    .crc_ok_i         (s_axis_tdata[S_CRC_BIT]),
    .event_counter_i  (s_axis_tdata[S_EC_LSB +: 8]),
    .chip_ident_i     (s_axis_tdata[S_CHIP_LSB +: 12]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .m_tready_i       (m_axis_tready),
    .m_tvalid_o       (m_axis_tvalid),
    .kind_o           (m_axis_tuser),
    .work_channel_o   (work_channel),
    .work_chip_o      (work_chip),
    .counters_agree_o (counters_agree),
    .working_count_o  (working_count),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = {working_count, counters_agree, work_chip, work_channel};

endmodule

// File: rtl/ecpc_checker.sv
`include "event_counter_progress_checker_core_assert.svh"

module ecpc_checker
  import ecpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [1:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  logic report_acc, entry_out, sum_out, out_stall;

  assign report_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_REPORT;
  assign entry_out  = m_axis_tvalid && m_axis_tuser == KIND_ENTRY;
  assign sum_out    = m_axis_tvalid && m_axis_tuser == KIND_SUMMARY;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;

  `ECPC_ASSERT_NXT(a_report_blocks_input, report_acc, !s_axis_tready)
  `ECPC_ASSERT_IMP(a_entry_fields, entry_out, !m_axis_tlast && m_axis_tdata[23:17] == 7'd0)
  `ECPC_ASSERT_IMP(a_summary_fields, sum_out, m_axis_tlast && m_axis_tdata[16:0] == 17'd0)
  `ECPC_ASSERT_NXT(a_stall_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind event_counter_progress_checker_core ecpc_checker u_ecpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ecpc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WRAP_FULL = 256;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_SHOWN = 10;

  // one input transaction; hold_first delays it until all reports are in
  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  chan;
    logic        fp_ok;
    logic        crc_ok;
    logic [7:0]  ec;
    logic [11:0] chip;
    logic        hold_first;
  } frame_item_t;

  // one result transaction
  typedef struct packed {
    logic        kind;
    logic [4:0]  chan;
    logic [11:0] chip;
    logic        agree;
    logic [5:0]  count;
    logic        last;
  } report_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [1:0]          s_axis_tuser = '0;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic [M_DATA_W-1:0] m_axis_tdata;

  event_counter_progress_checker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tdata  (m_axis_tdata)
  );

  frame_item_t item_q[$];
  report_t     report_q[$];
  frame_item_t cur_item;
  report_t     seen_rep;
  report_t     want_rep;
  int          queued = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          sink_stall = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;

  // tracked copy of the checker state
  logic        strict_q;
  logic        first_evt;
  logic        any_evt;
  logic [NUM_CHANNELS-1:0] known_m;
  logic [NUM_CHANNELS-1:0] bad_m;
  logic [NUM_CHANNELS-1:0] present_m;
  logic [7:0]  want_ec [NUM_CHANNELS];
  logic [7:0]  last_ec [NUM_CHANNELS];
  logic [11:0] last_chip [NUM_CHANNELS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_tracker();
    first_evt = 1'b1;
    any_evt   = 1'b0;
    known_m   = '0;
    bad_m     = '0;
    present_m = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      want_ec[i]   = '0;
      last_ec[i]   = '0;
      last_chip[i] = '0;
    end
  endtask

  // Update the tracked state for one accepted transaction and queue the
  // report transactions it causes.
  task automatic track_transaction(input frame_item_t it);
    report_t    rep;
    logic [7:0] ref_ec;
    logic       have;
    logic       agree;
    int         n;
    case (it.func)
      FUNC_FRAME: begin
        // frames before the first event start are dropped
        if (any_evt) begin
          present_m[it.chan] = 1'b1;
          last_ec[it.chan]   = it.ec;
          last_chip[it.chan] = it.chip;
          if (first_evt) known_m[it.chan] = 1'b1;
          if (known_m[it.chan] && !bad_m[it.chan]) begin
            if (!it.fp_ok || !it.crc_ok) bad_m[it.chan] = 1'b1;
            // non-strict mode lets the first event set the counter freely
            if (it.ec != want_ec[it.chan] && !(first_evt && !strict_q)) begin
              bad_m[it.chan] = 1'b1;
            end else begin
              want_ec[it.chan] =
                8'((int'(it.ec) + 1) % (strict_q ? MOD_STRICT : WRAP_FULL));
            end
          end
        end
      end
      FUNC_EVENT: begin
        if (any_evt) first_evt = 1'b0;
        any_evt   = 1'b1;
        present_m = '0;
      end
      FUNC_REPORT: begin
        have   = 1'b0;
        agree  = 1'b1;
        n      = 0;
        ref_ec = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (present_m[i] && !bad_m[i]) begin
            if (!have) begin
              ref_ec = last_ec[i];
              have   = 1'b1;
            end else if (last_ec[i] != ref_ec) begin
              agree = 1'b0;
            end
            rep      = '0;
            rep.kind = KIND_ENTRY;
            rep.chan = 5'(i);
            rep.chip = last_chip[i];
            report_q.insert(report_q.size(), rep);
            n++;
          end
        end
        rep       = '0;
        rep.kind  = KIND_SUMMARY;
        rep.agree = agree;
        rep.count = 6'(n);
        rep.last  = 1'b1;
        report_q.insert(report_q.size(), rep);
        clear_tracker();
      end
      default: ;
    endcase
  endtask

  function automatic frame_item_t frame_item(input int ch, input bit fp, input bit crc,
                                             input logic [7:0] ec, input logic [11:0] chip);
    frame_item_t it;
    it.func       = FUNC_FRAME;
    it.chan       = 5'(ch);
    it.fp_ok      = fp;
    it.crc_ok     = crc;
    it.ec         = ec;
    it.chip       = chip;
    it.hold_first = 1'b0;
    return it;
  endfunction

  function automatic frame_item_t ctrl_item(input logic [1:0] func);
    frame_item_t it;
    it      = '0;
    it.func = func;
    return it;
  endfunction

  function automatic void enqueue(input frame_item_t it);
    item_q.insert(item_q.size(), it);
    if (it.func != FUNC_UNUSED) queued++;
  endfunction

  // Queue one run: a group of events over a random set of channels with
  // advancing counters, some faults and noise unless clean, then a report.
  task automatic queue_event_run(input int n_events, input int n_ch, input bit clean,
                                 input bit hold);
    int          order [NUM_CHANNELS];
    logic [7:0]  ctr [NUM_CHANNELS];
    logic [11:0] id [NUM_CHANNELS];
    frame_item_t it;
    int          j, tmp, ch, rot, fault;
    bit          spread;
    logic [7:0]  base;
    for (int k = 0; k < NUM_CHANNELS; k++) order[k] = k;
    for (int k = NUM_CHANNELS - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    spread = 1'($urandom_range(0, 1));
    // start near the top now and then to cross the 256 wrap
    base = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      ctr[k] = strict_q ? 8'd0 : (spread ? 8'($urandom) : base);
      id[k]  = 12'($urandom);
    end
    // stray frame ahead of the first event start
    if (!clean && $urandom_range(0, 3) == 0) begin
      it = frame_item(order[0], 1'b1, 1'b1, 8'($urandom), 12'($urandom));
      it.hold_first = hold;
      hold = 1'b0;
      enqueue(it);
    end
    for (int e = 0; e < n_events; e++) begin
      it = ctrl_item(FUNC_EVENT);
      it.hold_first = hold;
      hold = 1'b0;
      enqueue(it);
      rot = (n_ch > 0) ? $urandom_range(0, n_ch - 1) : 0;
      for (int k = 0; k < n_ch; k++) begin
        ch = order[(k + rot) % n_ch];
        // drop this channel's frame for one event
        if (!clean && $urandom_range(0, 9) == 0) continue;
        it = frame_item(ch, 1'b1, 1'b1, ctr[ch], id[ch]);
        fault = clean ? 99 : $urandom_range(0, 24);
        case (fault)
          0: it.fp_ok = 1'b0;
          1: it.crc_ok = 1'b0;
          2: it.ec = it.ec ^ 8'($urandom_range(1, 255));
          3: begin
            id[ch]  = 12'($urandom);
            it.chip = id[ch];
          end
          default: ;
        endcase
        enqueue(it);
        if (fault == 4) enqueue(it);
        ctr[ch] = strict_q ? 8'((int'(ctr[ch]) + 1) % MOD_STRICT) : ctr[ch] + 8'd1;
      end
      // channel that joins after the first event is never checked
      if (!clean && e > 0 && n_ch < NUM_CHANNELS && $urandom_range(0, 7) == 0) begin
        enqueue(frame_item(order[n_ch], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           8'($urandom), 12'($urandom)));
      end
      if (!clean && $urandom_range(0, 19) == 0) enqueue(ctrl_item(FUNC_UNUSED));
    end
    enqueue(ctrl_item(FUNC_REPORT));
  endtask

  task automatic random_runs(input int target);
    while (queued < target) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_event_run($urandom_range(1, 2), $urandom_range(17, 32), 1'b0,
                        $urandom_range(0, 2) == 0);
      end else begin
        queue_event_run($urandom_range(1, 6), $urandom_range(0, 8), 1'b0,
                        $urandom_range(0, 2) == 0);
      end
    end
  endtask

  // Wait for the input queue and the report queue to drain, then settle.
  task automatic wait_idle();
    while (item_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_strict(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    strict_q = v;
  endtask

  task automatic note_mismatch(input string what, input report_t want, input report_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t %s: exp kind=%0d ch=%0d chip=%h agree=%0d cnt=%0d last=%0d", $time,
               what, want.kind, want.chan, want.chip, want.agree, want.count, want.last);
      $display("%0t %s: got kind=%0d ch=%0d chip=%h agree=%0d cnt=%0d last=%0d", $time,
               what, got.kind, got.chan, got.chip, got.agree, got.count, got.last);
    end
  endtask

  // Driver: present the next pending transaction once the slot is free.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) track_transaction(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() == 0 || (item_q[0].hold_first && report_q.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_item = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_item.func;
          s_axis_tdata  <= {5'b0, cur_item.chip, cur_item.ec, cur_item.crc_ok,
                            cur_item.fp_ok, cur_item.chan};
        end
      end
    end
  end

  // Monitor: check each report transaction, stall the sink in bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_rep.kind  = m_axis_tuser;
        seen_rep.chan  = m_axis_tdata[4:0];
        seen_rep.chip  = m_axis_tdata[16:5];
        seen_rep.agree = m_axis_tdata[17];
        seen_rep.count = m_axis_tdata[23:18];
        seen_rep.last  = m_axis_tlast;
        if (report_q.size() == 0) begin
          note_mismatch("unexpected report", '0, seen_rep);
        end else begin
          want_rep = report_q.pop_front();
          if (seen_rep !== want_rep) note_mismatch("report mismatch", want_rep, seen_rep);
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    strict_q = 1'b0;
    clear_tracker();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed, non-strict: noise, empty report, wraps, faults, late channel
    write_strict(1'b0);
    enqueue(ctrl_item(FUNC_UNUSED));
    enqueue(frame_item(3, 1'b1, 1'b1, 8'd7, 12'h123));
    enqueue(ctrl_item(FUNC_REPORT));
    enqueue(ctrl_item(FUNC_EVENT));
    enqueue(frame_item(0, 1'b0, 1'b1, 8'h00, 12'h000));
    enqueue(frame_item(31, 1'b1, 1'b1, 8'hff, 12'hfff));
    enqueue(frame_item(5, 1'b1, 1'b0, 8'h55, 12'haaa));
    enqueue(frame_item(7, 1'b1, 1'b1, 8'h0a, 12'h555));
    enqueue(frame_item(12, 1'b1, 1'b1, 8'haa, 12'h0f0));
    enqueue(ctrl_item(FUNC_EVENT));
    enqueue(frame_item(31, 1'b1, 1'b1, 8'h00, 12'hfff));
    enqueue(frame_item(7, 1'b1, 1'b1, 8'h0c, 12'h555));
    enqueue(frame_item(12, 1'b1, 1'b1, 8'hab, 12'h0f0));
    enqueue(ctrl_item(FUNC_UNUSED));
    enqueue(frame_item(9, 1'b1, 1'b1, 8'd200, 12'h321));
    enqueue(frame_item(9, 1'b0, 1'b0, 8'd3, 12'h654));
    enqueue(frame_item(0, 1'b1, 1'b1, 8'h01, 12'h111));
    enqueue(ctrl_item(FUNC_REPORT));
    wait_idle();

    // directed, strict: first event is checked against zero
    write_strict(1'b1);
    enqueue(ctrl_item(FUNC_EVENT));
    enqueue(frame_item(1, 1'b1, 1'b1, 8'd0, 12'h00f));
    enqueue(frame_item(2, 1'b1, 1'b1, 8'd5, 12'h0f0));
    enqueue(frame_item(4, 1'b1, 1'b1, 8'd255, 12'hf00));
    enqueue(ctrl_item(FUNC_EVENT));
    enqueue(frame_item(1, 1'b1, 1'b1, 8'd1, 12'h00f));
    enqueue(frame_item(1, 1'b1, 1'b1, 8'd2, 12'h0ff));
    enqueue(frame_item(2, 1'b1, 1'b1, 8'd1, 12'h0f0));
    enqueue(ctrl_item(FUNC_REPORT));

    // strict random: one long clean run across the 100 wrap, then mixed runs
    queue_event_run(102, 1, 1'b1, 1'b1);
    random_runs(260);
    wait_idle();

    // non-strict random with one full-width report
    write_strict(1'b0);
    queue_event_run(1, NUM_CHANNELS, 1'b1, 1'b0);
    random_runs(420);
    wait_idle();

    // final stretch with no idling on either side
    write_strict(1'b1);
    calm = 1'b1;
    random_runs(450);
    wait_idle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
